// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Token kind codes, character constants and shared types.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int LINE_BITS = 20;
    localparam int LINE_W    = 20;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [3:0] K_ID      = 4'd0;
    localparam logic [3:0] K_INT     = 4'd1;
    localparam logic [3:0] K_STRING  = 4'd2;
    localparam logic [3:0] K_ARROW   = 4'd3;
    localparam logic [3:0] K_LPAREN  = 4'd4;
    localparam logic [3:0] K_RPAREN  = 4'd5;
    localparam logic [3:0] K_COMMA   = 4'd6;
    localparam logic [3:0] K_EQUALS  = 4'd7;
    localparam logic [3:0] K_LBRACK  = 4'd8;
    localparam logic [3:0] K_RBRACK  = 4'd9;
    localparam logic [3:0] K_LBRACE  = 4'd10;
    localparam logic [3:0] K_RBRACE  = 4'd11;
    localparam logic [3:0] K_SEMI    = 4'd12;
    localparam logic [3:0] K_UNKNOWN = 4'd13;
    localparam logic [3:0] K_EOF     = 4'd14;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [4:0] {
        MODE_START = 5'b00001,
        MODE_IDENT = 5'b00010,
        MODE_INT   = 5'b00100,
        MODE_STR   = 5'b01000,
        MODE_DASH  = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] chr;
        logic       char_valid;
        logic       last;
    } t_tok;

    typedef struct packed {
        t_tok              tok;
        logic [LINE_W-1:0] line;
    } t_res;

endpackage

// ===== rtl/source_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer unit
// Lexes a byte stream into per-character token transactions.
// Path: the input byte is registered, then its results go to the result queue.
// Throughput: one byte per cycle while the result queue has room for two more
// results; a byte that yields two results (arrow, token end plus a new token)
// fills two entries of the four-entry result queue behind the single result port.
// Reset: start mode, line count one, input register and queue emptied.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] token_char, [8] char_valid,
                                        // [28:9] line_number, [31:29] zero
    output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    output logic        m_axis_tlast    // token_end
);

    localparam logic [stt_pkg::LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [stt_pkg::LINE_BITS-1:0] LINE_ONE =
        stt_pkg::LINE_BITS'(1);

    logic                            r_in_v;
    logic [7:0]                      r_in_byte;
    stt_pkg::t_mode                  r_mode, n_mode;
    logic [stt_pkg::LINE_BITS-1:0]   r_line, n_line;
    stt_pkg::t_res                   r_fifo [stt_pkg::FIFO_DEPTH];
    logic [stt_pkg::FIFO_AW-1:0]     r_wptr, r_rptr;
    logic [stt_pkg::FIFO_AW:0]       r_count, n_count;

    logic                            pop, adv;
    logic [stt_pkg::FIFO_AW:0]       count_left;
    logic [stt_pkg::FIFO_AW-1:0]     wptr_1;

    // Start-mode classification
    logic           sl_emit, sl_nl, sl_eof;
    stt_pkg::t_tok  sl_tok;
    stt_pkg::t_mode sl_mode;
    logic           is_alpha, is_digit;

    // Step result
    logic [1:0]     nres;
    stt_pkg::t_tok  e0, e1;
    logic           use_sl;

    assign pop        = m_axis_tvalid && m_axis_tready;
    assign count_left = r_count - (stt_pkg::FIFO_AW + 1)'(pop);
    assign adv        = r_in_v && (count_left <= (stt_pkg::FIFO_AW + 1)'(2));
    assign s_axis_tready = !r_in_v || adv;
    assign wptr_1     = r_wptr + stt_pkg::FIFO_AW'(1);

    always_comb begin
        is_alpha = (r_in_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], stt_pkg::CH_UNDER});
        is_digit = (r_in_byte inside {[8'h30:8'h39]});
    end

    always_comb begin
        sl_emit = 1'b0;
        sl_nl   = 1'b0;
        sl_eof  = 1'b0;
        sl_mode = stt_pkg::MODE_START;
        sl_tok  = '{kind: stt_pkg::K_UNKNOWN, chr: r_in_byte, char_valid: 1'b1,
                    last: 1'b1};
        if (r_in_byte inside {stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_CR,
                              stt_pkg::CH_LF}) begin
            sl_nl = (r_in_byte == stt_pkg::CH_LF);
        end else if (r_in_byte == stt_pkg::CH_NUL) begin
            sl_emit = 1'b1;
            sl_eof  = 1'b1;
            sl_tok  = '{kind: stt_pkg::K_EOF, chr: 8'd0, char_valid: 1'b0, last: 1'b1};
        end else if (is_alpha) begin
            sl_emit = 1'b1;
            sl_mode = stt_pkg::MODE_IDENT;
            sl_tok  = '{kind: stt_pkg::K_ID, chr: r_in_byte, char_valid: 1'b1,
                        last: 1'b0};
        end else if (is_digit) begin
            sl_emit = 1'b1;
            sl_mode = stt_pkg::MODE_INT;
            sl_tok  = '{kind: stt_pkg::K_INT, chr: r_in_byte, char_valid: 1'b1,
                        last: 1'b0};
        end else if (r_in_byte == stt_pkg::CH_DQUOTE) begin
            sl_mode = stt_pkg::MODE_STR;
        end else if (r_in_byte == stt_pkg::CH_DASH) begin
            sl_mode = stt_pkg::MODE_DASH;
        end else begin
            sl_emit = 1'b1;
            case (r_in_byte)
                stt_pkg::CH_LPAREN: sl_tok.kind = stt_pkg::K_LPAREN;
                stt_pkg::CH_RPAREN: sl_tok.kind = stt_pkg::K_RPAREN;
                stt_pkg::CH_COMMA:  sl_tok.kind = stt_pkg::K_COMMA;
                stt_pkg::CH_EQUALS: sl_tok.kind = stt_pkg::K_EQUALS;
                stt_pkg::CH_LBRACK: sl_tok.kind = stt_pkg::K_LBRACK;
                stt_pkg::CH_RBRACK: sl_tok.kind = stt_pkg::K_RBRACK;
                stt_pkg::CH_LBRACE: sl_tok.kind = stt_pkg::K_LBRACE;
                stt_pkg::CH_RBRACE: sl_tok.kind = stt_pkg::K_RBRACE;
                stt_pkg::CH_SEMI:   sl_tok.kind = stt_pkg::K_SEMI;
                default:            sl_tok.kind = stt_pkg::K_UNKNOWN;
            endcase
        end
    end

    always_comb begin
        nres   = 2'd0;
        e0     = sl_tok;
        e1     = sl_tok;
        use_sl = 1'b0;
        n_mode = r_mode;
        case (r_mode)
            stt_pkg::MODE_IDENT, stt_pkg::MODE_INT: begin
                e0.kind = (r_mode == stt_pkg::MODE_IDENT) ? stt_pkg::K_ID : stt_pkg::K_INT;
                if (is_digit || (is_alpha && r_mode == stt_pkg::MODE_IDENT)) begin
                    nres = 2'd1;
                    e0   = '{kind: e0.kind, chr: r_in_byte, char_valid: 1'b1, last: 1'b0};
                end else begin
                    use_sl = 1'b1;
                    e0     = '{kind: e0.kind, chr: 8'd0, char_valid: 1'b0, last: 1'b1};
                end
            end
            stt_pkg::MODE_STR: begin
                if (r_in_byte == stt_pkg::CH_DQUOTE) begin
                    nres   = 2'd1;
                    e0     = '{kind: stt_pkg::K_STRING, chr: 8'd0, char_valid: 1'b0,
                               last: 1'b1};
                    n_mode = stt_pkg::MODE_START;
                end else if (r_in_byte == stt_pkg::CH_NUL) begin
                    use_sl = 1'b1;
                    e0     = '{kind: stt_pkg::K_STRING, chr: 8'd0, char_valid: 1'b0,
                               last: 1'b1};
                end else begin
                    nres = 2'd1;
                    e0   = '{kind: stt_pkg::K_STRING, chr: r_in_byte, char_valid: 1'b1,
                             last: 1'b0};
                end
            end
            stt_pkg::MODE_DASH: begin
                if (r_in_byte == stt_pkg::CH_GT) begin
                    nres   = 2'd2;
                    e0     = '{kind: stt_pkg::K_ARROW, chr: stt_pkg::CH_DASH,
                               char_valid: 1'b1, last: 1'b0};
                    e1     = '{kind: stt_pkg::K_ARROW, chr: stt_pkg::CH_GT,
                               char_valid: 1'b1, last: 1'b1};
                    n_mode = stt_pkg::MODE_START;
                end else begin
                    use_sl = 1'b1;
                    e0     = '{kind: stt_pkg::K_UNKNOWN, chr: stt_pkg::CH_DASH,
                               char_valid: 1'b1, last: 1'b1};
                end
            end
            default: begin
                nres   = {1'b0, sl_emit};
                e0     = sl_tok;
                n_mode = sl_mode;
            end
        endcase
        if (use_sl) begin
            nres   = sl_emit ? 2'd2 : 2'd1;
            e1     = sl_tok;
            n_mode = sl_mode;
        end
    end

    always_comb begin
        n_line = r_line;
        if ((use_sl || r_mode == stt_pkg::MODE_START) && sl_nl && r_line != LINE_MAX) begin
            n_line = r_line + LINE_ONE;
        end else if ((use_sl || r_mode == stt_pkg::MODE_START) && sl_eof) begin
            n_line = LINE_ONE;
        end
    end

    always_comb begin
        n_count = count_left;
        if (adv) begin
            n_count = count_left + (stt_pkg::FIFO_AW + 1)'(nres);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mode  <= stt_pkg::MODE_START;
            r_line  <= LINE_ONE;
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_v <= s_axis_tvalid;
            end
            if (adv) begin
                r_mode <= n_mode;
                r_line <= n_line;
                r_wptr <= r_wptr + stt_pkg::FIFO_AW'(nres);
            end
            if (pop) begin
                r_rptr <= r_rptr + stt_pkg::FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (adv && nres != 2'd0) begin
            r_fifo[r_wptr] <= '{tok: e0, line: stt_pkg::LINE_W'(r_line)};
        end
        if (adv && nres == 2'd2) begin
            r_fifo[wptr_1] <= '{tok: e1, line: stt_pkg::LINE_W'(r_line)};
        end
    end

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {3'b000, r_fifo[r_rptr].line, r_fifo[r_rptr].tok.char_valid,
                            r_fifo[r_rptr].tok.chr};
    assign m_axis_tuser  = r_fifo[r_rptr].tok.kind;
    assign m_axis_tlast  = r_fifo[r_rptr].tok.last;

endmodule
